// ----- rtl/vsp_pkg.sv -----
// Package for the version-spec parser: phase and operator codes, character
// constants, state and result structs, and the output width helper.
// Depends on nothing; every rtl file imports it.
package vsp_pkg;

    // Number and store sizing.
    localparam int NUM_BITS    = 16;
    localparam int PRE_STORE   = 32;
    localparam int BUILD_STORE = 32;
    localparam int OUT_W       = 16;
    localparam int WIDE_W      = NUM_BITS + 4;
    localparam int MAX_STORE   = (PRE_STORE > BUILD_STORE) ? PRE_STORE : BUILD_STORE;
    localparam int CNT_W       = (MAX_STORE > 2) ? $clog2(MAX_STORE) : 1;
    localparam int RADIX       = 10;

    localparam logic [NUM_BITS-1:0] NUM_MAX = '1;

    // Characters that steer the parse.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Kinds of emitted text.
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_PRE   = 2'd1;
    localparam logic [1:0] KIND_BUILD = 2'd2;
    localparam logic [1:0] KIND_BAD   = 2'd3;

    typedef enum logic [2:0] {
        OP_ANY   = 3'd0,
        OP_EXACT = 3'd1,
        OP_CARET = 3'd2,
        OP_TILDE = 3'd3,
        OP_GTE   = 3'd4,
        OP_GT    = 3'd5,
        OP_LTE   = 3'd6,
        OP_LT    = 3'd7
    } t_op;

    typedef enum logic [3:0] {
        PH_START,
        PH_PX_CARET,
        PH_PX_TILDE,
        PH_PX_GT,
        PH_PX_LT,
        PH_PX_EQ,
        PH_ANY,
        PH_MAJ0,
        PH_MAJ,
        PH_MIN0,
        PH_MIN,
        PH_PAT0,
        PH_PAT,
        PH_PRE,
        PH_BLD,
        PH_TRAIL
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        t_op                 op;
        logic [NUM_BITS-1:0] major;
        logic [NUM_BITS-1:0] minor;
        logic [NUM_BITS-1:0] patch;
        logic [CNT_W-1:0]    cnt;
        logic                failed;
        logic                ovf;
    } t_state;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       pch;
        logic             done;
        logic             valid;
        t_op              op;
        logic [OUT_W-1:0] major;
        logic [OUT_W-1:0] minor;
        logic [OUT_W-1:0] patch;
        logic             ovf;
    } t_result;

    localparam t_state ST_RESET = '{
        phase:  PH_START,
        op:     OP_EXACT,
        major:  '0,
        minor:  '0,
        patch:  '0,
        cnt:    '0,
        failed: 1'b0,
        ovf:    1'b0
    };

    // Fit an accumulator into the result field width.
    function automatic logic [OUT_W-1:0] to_out(input logic [NUM_BITS-1:0] num);
        logic [OUT_W+NUM_BITS-1:0] ext;
        ext = {{OUT_W{1'b0}}, num};
        return ext[OUT_W-1:0];
    endfunction

endpackage

// ----- rtl/version_spec_parser.sv -----
// Top level of the version-spec parser: parse state register, step logic
// and the result register with its handshake.
// Depends on vsp_pkg and vsp_step.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_text_char, i_last
//  out     | output    | o_out_valid / i_out_ready | o_char_kind ... o_num_overflow
//
// An accepted item's result is written to the result register on the edge that accepts it.
// One item can be accepted every cycle; the parse state feeds back in one step.
// A stalled result holds the input side only while the result register is full
// and not being taken in the same cycle.
// Synchronous active-low reset clears the parse state and the result valid.
module version_spec_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_text_char,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_char_kind,
    output logic [7:0]  o_part_char,
    output logic        o_done_res,
    output logic        o_valid_res,
    output logic [2:0]  o_op_code,
    output logic [15:0] o_major_num,
    output logic [15:0] o_minor_num,
    output logic [15:0] o_patch_num,
    output logic        o_num_overflow
);
    import vsp_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_result n_res;
    t_result r_res;
    logic    r_out_valid;
    logic    n_out_valid;
    logic    w_in_acc;

    // Step logic for the current character.
    vsp_step u_step (
        .i_text_char (i_text_char),
        .i_last      (i_last),
        .i_state     (r_state),
        .o_state     (n_state),
        .o_res       (n_res)
    );

    // Accept whenever the result register is free or drains this cycle.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign n_out_valid = w_in_acc || (r_out_valid && !i_out_ready);

    // Parse state and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_in_acc) begin
                r_state <= n_state;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_char_kind    = r_res.kind;
    assign o_part_char    = r_res.pch;
    assign o_done_res     = r_res.done;
    assign o_valid_res    = r_res.valid;
    assign o_op_code      = r_res.op;
    assign o_major_num    = r_res.major;
    assign o_minor_num    = r_res.minor;
    assign o_patch_num    = r_res.patch;
    assign o_num_overflow = r_res.ovf;

    // Every accepted item leaves a result behind it.
    a_acc_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_out_valid)
        else $error("accepted item produced no result");

    // The end of a string restores the start-of-string state.
    a_end_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && n_res.done) |=>
        (r_state.phase == PH_START && r_state.cnt == '0 &&
         !r_state.failed && !r_state.ovf))
        else $error("parse state not restarted after string end");

    // Validity is only reported on the final result of a string.
    a_valid_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_res.valid || r_res.done))
        else $error("valid flag on a result that is not final");

    // Emitted text never carries the unused kind code.
    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_res.kind != KIND_BAD))
        else $error("illegal char kind");

endmodule

// ----- rtl/vsp_step.sv -----
// One-character step of the version-spec parser: prefix decode, version
// field parse with saturating decimal accumulate, and the result fields.
// Depends on vsp_pkg.
module vsp_step (
    input  logic [7:0]      i_text_char,
    input  logic            i_last,
    input  vsp_pkg::t_state i_state,
    output vsp_pkg::t_state o_state,
    output vsp_pkg::t_result o_res
);
    import vsp_pkg::*;

    t_state              ns;
    t_phase              vp;
    logic                do_ver;
    logic                end_s;
    logic                is_dig;
    logic                tgt_maj;
    logic                tgt_min;
    logic [NUM_BITS-1:0] acc_in;
    logic [WIDE_W-1:0]   wide;
    logic                sat;
    logic [NUM_BITS-1:0] sum;
    logic [1:0]          kind;
    logic [7:0]          pch;

    // Shared saturating multiply-by-ten and add for the selected number.
    // A character at the start or after a pending prefix goes to the major number.
    always_comb begin
        is_dig  = (i_text_char >= CH_ZERO) && (i_text_char <= CH_NINE);
        tgt_maj = (i_state.phase == PH_START) || (i_state.phase == PH_PX_CARET) ||
                  (i_state.phase == PH_PX_TILDE) || (i_state.phase == PH_PX_GT) ||
                  (i_state.phase == PH_PX_LT) || (i_state.phase == PH_PX_EQ) ||
                  (i_state.phase == PH_MAJ0) || (i_state.phase == PH_MAJ);
        tgt_min = (i_state.phase == PH_MIN0) || (i_state.phase == PH_MIN);
        acc_in  = tgt_maj ? i_state.major : (tgt_min ? i_state.minor : i_state.patch);
        wide    = WIDE_W'(acc_in) * WIDE_W'(RADIX)
                + WIDE_W'(i_text_char[3:0]);
        sat     = wide > WIDE_W'(NUM_MAX);
        sum     = sat ? NUM_MAX : wide[NUM_BITS-1:0];
    end

    // Prefix decode, then the version part of the character.
    always_comb begin
        ns     = i_state;
        vp     = i_state.phase;
        do_ver = 1'b0;
        kind   = KIND_NONE;
        pch    = '0;
        if (i_text_char == CH_NUL) begin
            end_s = 1'b1;
            if (i_state.phase == PH_START) begin
                ns.op    = OP_ANY;
                ns.phase = PH_ANY;
            end
        end else begin
            end_s = i_last;
            unique case (i_state.phase)
                PH_START: begin
                    unique case (i_text_char)
                        CH_CARET: begin ns.op = OP_CARET; ns.phase = PH_PX_CARET; end
                        CH_TILDE: begin ns.op = OP_TILDE; ns.phase = PH_PX_TILDE; end
                        CH_GT:    begin ns.op = OP_GT;    ns.phase = PH_PX_GT;    end
                        CH_LT:    begin ns.op = OP_LT;    ns.phase = PH_PX_LT;    end
                        CH_EQ:    begin ns.op = OP_EXACT; ns.phase = PH_PX_EQ;    end
                        CH_STAR:  begin ns.op = OP_ANY;   ns.phase = PH_ANY;      end
                        default: begin
                            ns.op  = OP_EXACT;
                            vp     = PH_MAJ0;
                            do_ver = 1'b1;
                        end
                    endcase
                end
                PH_PX_CARET, PH_PX_TILDE, PH_PX_GT, PH_PX_LT, PH_PX_EQ: begin
                    if (i_text_char == CH_EQ) begin
                        if (i_state.phase == PH_PX_GT) begin
                            ns.op = OP_GTE; ns.phase = PH_MAJ0;
                        end else if (i_state.phase == PH_PX_LT) begin
                            ns.op = OP_LTE; ns.phase = PH_MAJ0;
                        end else if (i_state.phase == PH_PX_EQ) begin
                            ns.op = OP_EXACT; ns.phase = PH_MAJ0;
                        end else begin
                            ns.op     = OP_EXACT;
                            ns.failed = 1'b1;
                            ns.phase  = PH_TRAIL;
                        end
                    end else if (i_state.phase == PH_PX_EQ) begin
                        ns.failed = 1'b1;
                        ns.phase  = PH_TRAIL;
                    end else begin
                        vp     = PH_MAJ0;
                        do_ver = 1'b1;
                    end
                end
                default: do_ver = 1'b1;
            endcase
        end

        if (do_ver) begin
            unique case (vp)
                PH_MAJ0, PH_MAJ: begin
                    if (is_dig) begin
                        ns.phase = PH_MAJ;
                        ns.major = sum;
                        ns.ovf   = i_state.ovf | sat;
                    end else if (vp == PH_MAJ && i_text_char == CH_DOT) begin
                        ns.phase = PH_MIN0;
                    end else begin
                        ns.failed = 1'b1;
                        ns.phase  = PH_TRAIL;
                    end
                end
                PH_MIN0, PH_MIN: begin
                    if (is_dig) begin
                        ns.phase = PH_MIN;
                        ns.minor = sum;
                        ns.ovf   = i_state.ovf | sat;
                    end else if (vp == PH_MIN && i_text_char == CH_DOT) begin
                        ns.phase = PH_PAT0;
                    end else begin
                        ns.failed = 1'b1;
                        ns.phase  = PH_TRAIL;
                    end
                end
                PH_PAT0, PH_PAT: begin
                    if (is_dig) begin
                        ns.phase = PH_PAT;
                        ns.patch = sum;
                        ns.ovf   = i_state.ovf | sat;
                    end else if (vp == PH_PAT0) begin
                        ns.failed = 1'b1;
                        ns.phase  = PH_TRAIL;
                    end else if (i_text_char == CH_DASH) begin
                        ns.phase = PH_PRE;
                        ns.cnt   = '0;
                    end else if (i_text_char == CH_PLUS) begin
                        ns.phase = PH_BLD;
                        ns.cnt   = '0;
                    end else begin
                        ns.phase = PH_TRAIL;
                    end
                end
                PH_PRE: begin
                    if (i_text_char == CH_PLUS) begin
                        ns.phase = PH_BLD;
                        ns.cnt   = '0;
                    end else if (i_state.cnt < CNT_W'(PRE_STORE - 1)) begin
                        kind   = KIND_PRE;
                        pch    = i_text_char;
                        ns.cnt = i_state.cnt + 1'b1;
                    end else begin
                        ns.phase = PH_TRAIL;
                    end
                end
                PH_BLD: begin
                    if (i_state.cnt < CNT_W'(BUILD_STORE - 1)) begin
                        kind   = KIND_BUILD;
                        pch    = i_text_char;
                        ns.cnt = i_state.cnt + 1'b1;
                    end else begin
                        ns.phase = PH_TRAIL;
                    end
                end
                default: ;
            endcase
        end
    end

    // Result fields and the state handed back; the string end restarts.
    always_comb begin
        o_res.kind  = kind;
        o_res.pch   = pch;
        o_res.done  = end_s;
        o_res.valid = end_s && !ns.failed &&
                      (ns.phase == PH_ANY || ns.phase == PH_PAT ||
                       ns.phase == PH_PRE || ns.phase == PH_BLD ||
                       ns.phase == PH_TRAIL);
        o_res.op    = ns.op;
        o_res.major = to_out(ns.major);
        o_res.minor = to_out(ns.minor);
        o_res.patch = to_out(ns.patch);
        o_res.ovf   = ns.ovf;
        o_state     = end_s ? ST_RESET : ns;
    end

endmodule
